>>> hdl/tccb_pkg.sv
package tccb_pkg;

	localparam int MAX_LINES   = 32;
	localparam int MAX_COLUMNS = 64;
	localparam int CELLS       = MAX_LINES * MAX_COLUMNS;
	localparam int ADDR_W      = $clog2(CELLS);

	localparam int LINE_W     = 5;
	localparam int COL_W      = 6;
	localparam int CHAR_W     = 8;
	localparam int MODE_W     = 2;
	localparam int LCNT_W     = 6;
	localparam int CCNT_W     = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 7;

	typedef logic [LINE_W-1:0] line_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t NUL_CODE     = 8'd0;
	localparam char_t NEWLINE_CODE = 8'd10;
	localparam char_t SPACE_CODE   = 8'd32;

	localparam logic [LCNT_W-1:0] LINE_COUNT_RESET   = 6'd32;
	localparam logic [CCNT_W-1:0] COLUMN_COUNT_RESET = 7'd64;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT  = 2'd0,
		MODE_SET  = 2'd1,
		MODE_READ = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 4'd1;

	typedef struct packed {
		line_t last_line;
		col_t  last_col;
	} area_t;

	typedef struct packed {
		logic  we;
		addr_t addr;
		char_t data;
	} mem_wr_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		char_t             char_code;
		line_t             line_sel;
		col_t              column_sel;
	} item_t;

	typedef struct packed {
		line_t cursor_line;
		col_t  cursor_column;
		logic  scrolled;
		char_t cell_glyph;
		logic  draw_needed;
	} result_t;

	function automatic addr_t cell_addr(line_t line, col_t col);
		cell_addr = ADDR_W'(int'(line) * MAX_COLUMNS + int'(col));
	endfunction

endpackage

>>> hdl/tccb_channels.sv
interface tccb_req_if;
	import tccb_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	char_t             char_code;
	line_t             line_sel;
	col_t              column_sel;

	modport source (output valid, output mode, output char_code, output line_sel,
		output column_sel, input ready);
	modport sink (input valid, input mode, input char_code, input line_sel,
		input column_sel, output ready);
endinterface

interface tccb_rsp_if;
	import tccb_pkg::*;
	logic  valid;
	logic  ready;
	line_t cursor_line;
	col_t  cursor_column;
	logic  scrolled;
	char_t cell_glyph;
	logic  draw_needed;

	modport source (output valid, output cursor_line, output cursor_column,
		output scrolled, output cell_glyph, output draw_needed, input ready);
	modport sink (input valid, input cursor_line, input cursor_column,
		input scrolled, input cell_glyph, input draw_needed, output ready);
endinterface

interface tccb_cfg_if;
	import tccb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/tccb_store.sv
module tccb_store (
	input  logic             clk,
	input  tccb_pkg::addr_t   rd_addr,
	input  tccb_pkg::mem_wr_t text_wr,
	input  tccb_pkg::mem_wr_t drawn_wr,
	output tccb_pkg::char_t   text_rd,
	output tccb_pkg::char_t   drawn_rd
);
	import tccb_pkg::*;

	char_t text_mem  [CELLS];
	char_t drawn_mem [CELLS];

	always_ff @(posedge clk) begin
		if (text_wr.we) begin
			text_mem[text_wr.addr] <= text_wr.data;
		end
		text_rd <= text_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (drawn_wr.we) begin
			drawn_mem[drawn_wr.addr] <= drawn_wr.data;
		end
		drawn_rd <= drawn_mem[rd_addr];
	end

endmodule

>>> hdl/tccb_ctrl.sv
module tccb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  tccb_pkg::area_t   area,
	input  logic              in_valid,
	output logic              in_ready,
	input  tccb_pkg::item_t   item,
	output logic              res_valid,
	output tccb_pkg::result_t res,
	input  logic              out_free,
	output tccb_pkg::addr_t   rd_addr,
	output tccb_pkg::mem_wr_t text_wr,
	output tccb_pkg::mem_wr_t drawn_wr,
	input  tccb_pkg::char_t   text_rd,
	input  tccb_pkg::char_t   drawn_rd
);
	import tccb_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_EXEC   = 7'b0000100,
		S_READ   = 7'b0001000,
		S_SCROLL = 7'b0010000,
		S_DRAIN  = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;
	item_t  item_q;
	line_t  cur_line_q;
	col_t   cur_col_q;
	logic   redraw_q;
	logic   scrolled_q;
	char_t  glyph_q;
	logic   need_q;
	addr_t  clr_q;
	line_t  sl_q;
	col_t   sc_q;
	logic   wv_s1;
	addr_t  wa_s1;
	logic   wblank_s1;

	mode_t             mode;
	line_t             cl;
	col_t              cc;
	logic              is_nl;
	logic              wrap;
	logic [COL_W:0]    col_inc;
	logic [LINE_W:0]   nline;
	col_t              ncol;
	logic              need_scroll;
	line_t             set_line;
	col_t              set_col;
	logic              in_area;
	logic              last_cell;
	logic              differ;
	char_t             rd_glyph;
	logic              rd_need;
	addr_t             sel_addr;

	always_comb begin
		mode        = mode_t'(item_q.mode);
		cl          = (cur_line_q > area.last_line) ? area.last_line : cur_line_q;
		cc          = (cur_col_q > area.last_col) ? area.last_col : cur_col_q;
		is_nl       = (item_q.char_code == NEWLINE_CODE);
		col_inc     = {1'b0, cc} + (COL_W+1)'(1);
		wrap        = !is_nl && (col_inc > {1'b0, area.last_col});
		nline       = {1'b0, cl} + ((is_nl || wrap) ? (LINE_W+1)'(1) : (LINE_W+1)'(0));
		ncol        = (is_nl || wrap) ? '0 : col_inc[COL_W-1:0];
		need_scroll = (nline > {1'b0, area.last_line});
		set_line    = (item_q.line_sel > area.last_line) ? area.last_line : item_q.line_sel;
		set_col     = (item_q.column_sel > area.last_col) ? area.last_col : item_q.column_sel;
		in_area     = (item_q.line_sel <= area.last_line) && (item_q.column_sel <= area.last_col);
		last_cell   = (item_q.line_sel == area.last_line) && (item_q.column_sel == area.last_col);
		sel_addr    = cell_addr(item_q.line_sel, item_q.column_sel);
		differ      = (text_rd != drawn_rd) || redraw_q;
		rd_glyph    = NUL_CODE;
		rd_need     = 1'b0;
		if (differ) begin
			if (text_rd >= SPACE_CODE) begin
				rd_glyph = text_rd;
				rd_need  = 1'b1;
			end else if (redraw_q) begin
				rd_glyph = SPACE_CODE;
				rd_need  = 1'b1;
			end
		end
	end

	// one shared port per store: clear pass, item access and scroll sweep
	always_comb begin
		rd_addr  = (state_q == S_SCROLL) ? cell_addr(sl_q + LINE_W'(1), sc_q) : sel_addr;
		text_wr  = '0;
		drawn_wr = '0;
		case (state_q)
			S_CLEAR: begin
				text_wr  = '{we: 1'b1, addr: clr_q, data: NUL_CODE};
				drawn_wr = '{we: 1'b1, addr: clr_q, data: NUL_CODE};
			end
			S_EXEC: begin
				if (mode == MODE_PUT && item_q.char_code != NUL_CODE && !is_nl) begin
					text_wr = '{we: 1'b1, addr: cell_addr(cl, cc), data: item_q.char_code};
				end
			end
			S_READ: begin
				drawn_wr = '{we: 1'b1, addr: sel_addr, data: text_rd};
			end
			default: begin
				if (wv_s1) begin
					text_wr  = '{we: 1'b1, addr: wa_s1,
						data: wblank_s1 ? SPACE_CODE : text_rd};
					drawn_wr = '{we: 1'b1, addr: wa_s1, data: NUL_CODE};
				end
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT) && out_free;
	assign res       = '{cursor_line: cur_line_q, cursor_column: cur_col_q,
		scrolled: scrolled_q, cell_glyph: glyph_q, draw_needed: need_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			item_q     <= '0;
			cur_line_q <= '0;
			cur_col_q  <= '0;
			redraw_q   <= 1'b1;
			scrolled_q <= 1'b0;
			glyph_q    <= '0;
			need_q     <= 1'b0;
			clr_q      <= '0;
			sl_q       <= '0;
			sc_q       <= '0;
			wv_s1      <= 1'b0;
			wa_s1      <= '0;
			wblank_s1  <= 1'b0;
		end else begin
			wv_s1 <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q     <= item;
						scrolled_q <= 1'b0;
						glyph_q    <= NUL_CODE;
						need_q     <= 1'b0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_EMIT;
					case (mode)
						MODE_PUT: begin
							if (item_q.char_code != NUL_CODE) begin
								if (need_scroll) begin
									scrolled_q <= 1'b1;
									sl_q       <= '0;
									sc_q       <= '0;
									state_q    <= S_SCROLL;
								end else begin
									cur_line_q <= nline[LINE_W-1:0];
									cur_col_q  <= ncol;
								end
							end
						end
						MODE_SET: begin
							cur_line_q <= set_line;
							cur_col_q  <= set_col;
						end
						MODE_READ: begin
							if (in_area) begin
								state_q <= S_READ;
							end
						end
						default: begin
							state_q <= S_EMIT;
						end
					endcase
				end
				S_READ: begin
					glyph_q <= rd_glyph;
					need_q  <= rd_need;
					if (last_cell) begin
						redraw_q <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_SCROLL: begin
					wv_s1     <= 1'b1;
					wa_s1     <= cell_addr(sl_q, sc_q);
					wblank_s1 <= (sl_q == area.last_line);
					if (sc_q == area.last_col) begin
						sc_q <= '0;
						if (sl_q == area.last_line) begin
							state_q <= S_DRAIN;
						end else begin
							sl_q <= sl_q + LINE_W'(1);
						end
					end else begin
						sc_q <= sc_q + COL_W'(1);
					end
				end
				S_DRAIN: begin
					cur_line_q <= area.last_line;
					cur_col_q  <= '0;
					redraw_q   <= 1'b1;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/text_console_cell_buffer.sv
// put, set cursor: exec then emit to the output register; cell read: exec, read, emit
// a put that scrolls goes exec, scroll (every cell of the area), drain, emit
// one item at a time: a new item is accepted only after the last result leaves emit
// reset: control and config registers take their reset values at once, then a clearing
// pass zeroes both stores while no item is accepted; config writes always taken
module text_console_cell_buffer (
	input  logic clk,
	input  logic arst_n,
	tccb_req_if.sink   req,
	tccb_rsp_if.source rsp,
	tccb_cfg_if.sink   cfg
);
	import tccb_pkg::*;

	logic [LCNT_W-1:0] lines_q;
	logic [CCNT_W-1:0] cols_q;
	area_t             area;
	item_t             item;
	result_t           res;
	logic              res_valid;
	logic              out_free;
	logic              out_valid_q;
	result_t           out_q;
	addr_t             rd_addr;
	mem_wr_t           text_wr;
	mem_wr_t           drawn_wr;
	char_t             text_rd;
	char_t             drawn_rd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= LINE_COUNT_RESET;
			cols_q  <= COLUMN_COUNT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LINE_COUNT:   lines_q <= cfg.data[LCNT_W-1:0];
				REG_COLUMN_COUNT: cols_q  <= cfg.data[CCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// area in use, zero acts as one and large values saturate
	always_comb begin
		if (lines_q == '0) begin
			area.last_line = '0;
		end else if (lines_q > LCNT_W'(MAX_LINES)) begin
			area.last_line = LINE_W'(MAX_LINES - 1);
		end else begin
			area.last_line = LINE_W'(lines_q - LCNT_W'(1));
		end
		if (cols_q == '0) begin
			area.last_col = '0;
		end else if (cols_q > CCNT_W'(MAX_COLUMNS)) begin
			area.last_col = COL_W'(MAX_COLUMNS - 1);
		end else begin
			area.last_col = COL_W'(cols_q - CCNT_W'(1));
		end
	end

	assign item = '{mode: req.mode, char_code: req.char_code,
		line_sel: req.line_sel, column_sel: req.column_sel};

	tccb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.area      (area),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.item      (item),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.rd_addr   (rd_addr),
		.text_wr   (text_wr),
		.drawn_wr  (drawn_wr),
		.text_rd   (text_rd),
		.drawn_rd  (drawn_rd)
	);

	tccb_store u_store (
		.clk      (clk),
		.rd_addr  (rd_addr),
		.text_wr  (text_wr),
		.drawn_wr (drawn_wr),
		.text_rd  (text_rd),
		.drawn_rd (drawn_rd)
	);

	// output register
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.cursor_line   = out_q.cursor_line;
	assign rsp.cursor_column = out_q.cursor_column;
	assign rsp.scrolled      = out_q.scrolled;
	assign rsp.cell_glyph    = out_q.cell_glyph;
	assign rsp.draw_needed   = out_q.draw_needed;

endmodule

>>> hdl/tccb_checker.sv
module tccb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input tccb_pkg::col_t  rsp_cursor_column,
	input logic            rsp_scrolled,
	input tccb_pkg::char_t rsp_cell_glyph,
	input logic            rsp_draw_needed
);
	import tccb_pkg::*;

	// one item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("item accepted while previous item in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result dropped while stalled");

	// a scroll leaves the cursor at the start of the bottom line
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_scrolled) |-> (rsp_cursor_column == '0))
		else $error("scroll result with cursor off column zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_draw_needed) |-> (rsp_cell_glyph == NUL_CODE))
		else $error("glyph reported for a cell that needs no drawing");

endmodule

bind text_console_cell_buffer tccb_checker u_tccb_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_cursor_column (rsp.cursor_column),
	.rsp_scrolled      (rsp.scrolled),
	.rsp_cell_glyph    (rsp.cell_glyph),
	.rsp_draw_needed   (rsp.draw_needed)
);

>>> tb/tb_text_console_cell_buffer.sv
import tccb_pkg::*;

class console_scoreboard;
	char_t             text_cells[CELLS];
	char_t             drawn_cells[CELLS];
	int                cur_line;
	int                cur_column;
	bit                redraw_all;
	logic [LCNT_W-1:0] line_count;
	logic [CCNT_W-1:0] column_count;
	result_t           awaited[$];
	int                failures;

	function new();
		foreach (text_cells[i]) begin
			text_cells[i] = NUL_CODE;
			drawn_cells[i] = NUL_CODE;
		end
		cur_line = 0;
		cur_column = 0;
		redraw_all = 1'b1;
		line_count = LINE_COUNT_RESET;
		column_count = COLUMN_COUNT_RESET;
		failures = 0;
	endfunction

	function int visible_lines();
		if (line_count == 0)
			return 1;
		if (line_count > MAX_LINES)
			return MAX_LINES;
		return int'(line_count);
	endfunction

	function int visible_columns();
		if (column_count == 0)
			return 1;
		if (column_count > MAX_COLUMNS)
			return MAX_COLUMNS;
		return int'(column_count);
	endfunction

	function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		if (index == REG_LINE_COUNT)
			line_count = data[LCNT_W-1:0];
		else if (index == REG_COLUMN_COUNT)
			column_count = data[CCNT_W-1:0];
	endfunction

	function void scroll_text(int lines, int cols);
		for (int l = 1; l < lines; l++)
			for (int c = 0; c < cols; c++)
				text_cells[(l - 1) * MAX_COLUMNS + c] = text_cells[l * MAX_COLUMNS + c];
		for (int c = 0; c < cols; c++)
			text_cells[(lines - 1) * MAX_COLUMNS + c] = SPACE_CODE;
		for (int l = 0; l < lines; l++)
			for (int c = 0; c < cols; c++)
				drawn_cells[l * MAX_COLUMNS + c] = NUL_CODE;
		cur_line = lines - 1;
		cur_column = 0;
		redraw_all = 1'b1;
	endfunction

	function void note_item(item_t it);
		int      lines;
		int      cols;
		int      idx;
		char_t   t;
		result_t r;
		lines = visible_lines();
		cols = visible_columns();
		r = '0;
		case (mode_t'(it.mode))
		MODE_PUT: begin
			if (it.char_code != NUL_CODE) begin
				if (cur_line >= lines)
					cur_line = lines - 1;
				if (cur_column >= cols)
					cur_column = cols - 1;
				if (it.char_code == NEWLINE_CODE) begin
					cur_column = 0;
					cur_line++;
				end else begin
					text_cells[cur_line * MAX_COLUMNS + cur_column] = it.char_code;
					cur_column++;
				end
				if (cur_column >= cols) begin
					cur_column = 0;
					cur_line++;
				end
				if (cur_line >= lines) begin
					scroll_text(lines, cols);
					r.scrolled = 1'b1;
				end
			end
		end
		MODE_SET: begin
			cur_line = (int'(it.line_sel) > lines - 1) ? lines - 1 : int'(it.line_sel);
			cur_column = (int'(it.column_sel) > cols - 1) ? cols - 1 : int'(it.column_sel);
		end
		MODE_READ: begin
			if (int'(it.line_sel) < lines && int'(it.column_sel) < cols) begin
				idx = int'(it.line_sel) * MAX_COLUMNS + int'(it.column_sel);
				t = text_cells[idx];
				if (t != drawn_cells[idx] || redraw_all) begin
					if (t >= SPACE_CODE) begin
						r.cell_glyph = t;
						r.draw_needed = 1'b1;
					end else if (redraw_all) begin
						r.cell_glyph = SPACE_CODE;
						r.draw_needed = 1'b1;
					end
				end
				drawn_cells[idx] = t;
				if (int'(it.line_sel) == lines - 1 && int'(it.column_sel) == cols - 1)
					redraw_all = 1'b0;
			end
		end
		default: ;
		endcase
		r.cursor_line = line_t'(cur_line);
		r.cursor_column = col_t'(cur_column);
		awaited.push_back(r);
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (awaited.size() == 0) begin
			$error("result with no item pending");
			failures++;
			return;
		end
		want = awaited.pop_front();
		if (got.cursor_line !== want.cursor_line) begin
			$error("cursor_line expected %0d actual %0d", want.cursor_line, got.cursor_line);
			failures++;
		end
		if (got.cursor_column !== want.cursor_column) begin
			$error("cursor_column expected %0d actual %0d", want.cursor_column,
				got.cursor_column);
			failures++;
		end
		if (got.scrolled !== want.scrolled) begin
			$error("scrolled expected %0d actual %0d", want.scrolled, got.scrolled);
			failures++;
		end
		if (got.cell_glyph !== want.cell_glyph) begin
			$error("cell_glyph expected %0d actual %0d", want.cell_glyph, got.cell_glyph);
			failures++;
		end
		if (got.draw_needed !== want.draw_needed) begin
			$error("draw_needed expected %0d actual %0d", want.draw_needed, got.draw_needed);
			failures++;
		end
	endfunction

	function int close_out();
		if (awaited.size() != 0) begin
			$error("%0d results never arrived", awaited.size());
			failures++;
		end
		return failures;
	endfunction
endclass

module tb_text_console_cell_buffer;

	localparam int                   STALL_LIMIT = 20000;
	localparam int                   HOLD_CYCLES = 300;
	localparam int                   PHASES      = 9;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 4'hF;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tccb_req_if req_ch();
	tccb_rsp_if rsp_ch();
	tccb_cfg_if cfg_ch();

	console_scoreboard sb = new();

	int items_accepted  = 0;
	int results_checked = 0;
	int stalled_cycles  = 0;
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	bit hold_output     = 1'b0;

	int phase_lines[PHASES] = '{1, 0, 4, 2, 63, 5, 32, 127, 3};
	int phase_cols[PHASES]  = '{1, 0, 8, 3, 127, 64, 1, 2, 6};
	int phase_items[PHASES] = '{45, 45, 45, 45, 20, 45, 45, 45, 45};

	text_console_cell_buffer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			sb.note_item({req_ch.mode, req_ch.char_code, req_ch.line_sel, req_ch.column_sel});
		if (rsp_ch.valid && rsp_ch.ready) begin
			sb.check_result({rsp_ch.cursor_line, rsp_ch.cursor_column, rsp_ch.scrolled,
				rsp_ch.cell_glyph, rsp_ch.draw_needed});
			results_checked++;
		end
		if (cfg_ch.valid && cfg_ch.ready)
			sb.set_register(cfg_ch.index, cfg_ch.data);
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_output) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic char_t pick_char();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return char_t'($urandom_range(32, 126));
		4, 5: return NEWLINE_CODE;
		6: return char_t'($urandom_range(1, 31));
		7: return NUL_CODE;
		default: return char_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(mode_t op, char_t ch, line_t ln, col_t cl);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= op;
		req_ch.char_code <= ch;
		req_ch.line_sel <= ln;
		req_ch.column_sel <= cl;
		do @(posedge clk); while (!req_ch.ready);
		items_accepted++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (results_checked != items_accepted) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic configure(int lines, int cols, bit stray);
		wait_drained();
		write_register(REG_LINE_COUNT, CFG_DATA_W'(lines));
		if (stray)
			write_register(REG_UNUSED, '1);
		write_register(REG_COLUMN_COUNT, CFG_DATA_W'(cols));
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int lines;
		int cols;
		int burst_len;
		int phase_start;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_PUT;
		req_ch.char_code <= NUL_CODE;
		req_ch.line_sel <= '0;
		req_ch.column_sel <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_LINE_COUNT;
		cfg_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 24;
		recv_idle_pct = 83;

		// full screen, redraw-all set after reset
		send_item(MODE_READ, NUL_CODE, 0, 0);
		send_item(MODE_PUT, 8'h41, 0, 0);
		send_item(MODE_PUT, 8'hFF, 0, 0);
		send_item(MODE_PUT, 8'h01, 0, 0);
		send_item(MODE_PUT, NUL_CODE, 31, 63);
		send_item(MODE_PUT, SPACE_CODE, 0, 0);
		send_item(MODE_PUT, NEWLINE_CODE, 0, 0);
		send_item(MODE_READ, NUL_CODE, 0, 0);
		send_item(MODE_READ, 8'hFF, 0, 2);
		send_item(MODE_READ, NUL_CODE, 31, 63);
		// redraw-all now clear: control char and unchanged cells are skipped
		send_item(MODE_READ, NUL_CODE, 0, 2);
		send_item(MODE_READ, NUL_CODE, 0, 0);
		send_item(MODE_READ, NUL_CODE, 0, 1);
		send_item(MODE_NONE, 8'hFF, 31, 63);
		send_item(MODE_SET, NUL_CODE, 31, 63);
		send_item(MODE_PUT, 8'h5A, 0, 0);
		send_item(MODE_READ, NUL_CODE, 31, 63);
		send_item(MODE_PUT, NEWLINE_CODE, 0, 0);
		send_item(MODE_SET, NUL_CODE, 20, 50);

		// shrink with the cursor left outside the area
		configure(3, 4, 1'b1);
		send_item(MODE_PUT, 8'h78, 0, 0);
		send_item(MODE_SET, NUL_CODE, 31, 63);
		send_item(MODE_READ, NUL_CODE, 3, 0);
		send_item(MODE_READ, NUL_CODE, 0, 4);
		send_item(MODE_READ, NUL_CODE, 2, 3);
		send_item(MODE_PUT, 8'h7F, 0, 0);

		for (int p = 0; p < PHASES; p++) begin
			configure(phase_lines[p], phase_cols[p], p == 1);
			send_idle_pct = (p < 3) ? 24 : (p < 6) ? 83 : 0;
			recv_idle_pct = (p < 3) ? 83 : (p < 6) ? 24 : 0;
			if (p == PHASES - 1)
				hold_output = 1'b1;
			lines = sb.visible_lines();
			cols = sb.visible_columns();
			phase_start = items_accepted;
			while (items_accepted - phase_start < phase_items[p]) begin
				case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					burst_len = $urandom_range(1, (3 * cols > 24) ? 24 : 3 * cols);
					repeat (burst_len)
						send_item(MODE_PUT, pick_char(), line_t'($urandom_range(0, 31)),
							col_t'($urandom_range(0, 63)));
					if (lines * cols <= 64) begin
						for (int l = 0; l < lines; l++)
							for (int c = 0; c < cols; c++)
								send_item(MODE_READ, char_t'($urandom_range(0, 255)),
									line_t'(l), col_t'(c));
					end else begin
						repeat ($urandom_range(1, 6))
							send_item(MODE_READ, char_t'($urandom_range(0, 255)),
								line_t'($urandom_range(0, lines - 1)),
								col_t'($urandom_range(0, cols - 1)));
					end
				end
				4, 5: begin
					send_item(MODE_SET, char_t'($urandom_range(0, 255)),
						line_t'($urandom_range(0, 31)), col_t'($urandom_range(0, 63)));
					repeat ($urandom_range(1, 3))
						send_item(MODE_PUT, pick_char(), 0, 0);
				end
				6, 7: begin
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 3) == 0)
							send_item(MODE_READ, char_t'($urandom_range(0, 255)),
								line_t'($urandom_range(0, 31)),
								col_t'($urandom_range(0, 63)));
						else
							send_item(MODE_READ, char_t'($urandom_range(0, 255)),
								line_t'($urandom_range(0, lines - 1)),
								col_t'($urandom_range(0, cols - 1)));
					end
				end
				8: begin
					send_item(mode_t'($urandom_range(0, 3)), char_t'($urandom_range(0, 255)),
						line_t'($urandom_range(0, 31)), col_t'($urandom_range(0, 63)));
				end
				default: begin
					repeat ($urandom_range(1, 3))
						send_item(MODE_PUT, NEWLINE_CODE, 0, 0);
				end
				endcase
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.close_out() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
